/* rtl/sis_pkg.sv */
// Shared constants for the segment crossing pipeline.
// Used by the top level, the pipelined divider and the port checker.
package sis_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int HALF_W         = 16;
    localparam int RES_W          = 32;
    // quotient bits of the doubled numerator; enough to see saturation
    localparam int QUO_BITS       = 34;

    localparam logic [RES_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] NEG_MIN = 32'h8000_0000;

endpackage

/* rtl/sis_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on sis_pkg; instantiated twice by segment_intersection_with_sides.
module sis_div
    import sis_pkg::*;
#(
    parameter int NW = 56,
    parameter int DW = 37,
    parameter int QB = QUO_BITS
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] quo,
    output logic          ovf
);

    localparam int HW   = NW - QB;
    localparam int CMPW = (HW > DW) ? HW : DW;

    logic [DW-1:0] rem_reg [QB+1];
    logic [QB-1:0] lo_reg  [QB];
    logic [QB-1:0] q_reg   [QB+1];
    logic [DW-1:0] den_reg [QB];
    logic          ovf_reg [QB+1];

    logic [HW-1:0] hi_next;
    logic          ovf_next;

    assign hi_next  = num[NW-1:QB];
    // quotient needs more than QB bits
    assign ovf_next = CMPW'(hi_next) >= CMPW'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(hi_next);
            lo_reg[0]  <= num[QB-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [DW:0] trial_next;
        logic        ge_next;

        assign trial_next = {rem_reg[k-1], lo_reg[k-1][QB-1]};
        assign ge_next    = trial_next >= {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge_next ? DW'(trial_next - {1'b0, den_reg[k-1]})
                                      : trial_next[DW-1:0];
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge_next};
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k < QB)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lo_reg[k]  <= {lo_reg[k-1][QB-2:0], 1'b0};
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo = q_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

/* rtl/segment_intersection_with_sides.sv */
// Segment pair crossing point, bounding-range hit and inner-side tests.
// Throughput: one word per cycle; the whole pipeline advances when the output
// register is empty or being taken, and holds otherwise.
// The divider depth (one quotient bit per stage) sets the latency.
// Reset (rst_n low, asynchronous) clears all valid bits; data is not reset.
module segment_intersection_with_sides
    import sis_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [31:0]             ref_start,
    input  logic [31:0]             ref_end,
    input  logic [31:0]             ref_offset,
    input  logic                    ref_inner,
    input  logic [31:0]             ext_start,
    input  logic [31:0]             ext_end,
    input  logic [31:0]             ext_offset,
    input  logic                    ext_inner,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    intersected,
    output logic signed [RES_W-1:0] cross_x,
    output logic signed [RES_W-1:0] cross_y,
    output logic                    ref_incoming,
    output logic                    ext_incoming
);

    localparam int CW   = (COORD_BITS > HALF_W) ? HALF_W : COORD_BITS;
    localparam int PW   = CW + 1;
    localparam int DW   = PW + 1;
    localparam int MW   = DW + PW;
    localparam int CB   = MW + 1;
    localparam int PPW  = 2 * DW;
    localparam int DETW = PPW + 1;
    localparam int NUMW = DW + CB + 1;
    localparam int N2W  = NUMW + 1;
    localparam int NXW  = (N2W > QUO_BITS + 1) ? N2W : QUO_BITS + 1;
    localparam int QB   = QUO_BITS;
    localparam int NST  = QB + 10;

    typedef struct packed {
        logic signed [PW-1:0] xlo;
        logic signed [PW-1:0] xhi;
        logic signed [PW-1:0] ylo;
        logic signed [PW-1:0] yhi;
        logic                 detz;
        logic                 negx;
        logic                 negy;
        logic                 rinc;
        logic                 einc;
    } side_t;

    logic            en;
    logic [NST-1:0]  vld_reg;

    assign en       = out_ready || !vld_reg[NST-1];
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // stage A: unpack and translate
    logic signed [PW-1:0] a_r0x_next, a_r0y_next, a_r1x_next, a_r1y_next;
    logic signed [PW-1:0] a_e0x_next, a_e0y_next, a_e1x_next, a_e1y_next;
    logic signed [PW-1:0] a_r0x_reg, a_r0y_reg, a_r1x_reg, a_r1y_reg;
    logic signed [PW-1:0] a_e0x_reg, a_e0y_reg, a_e1x_reg, a_e1y_reg;
    logic                 a_rin_reg, a_ein_reg;

    assign a_r0x_next = PW'(signed'(ref_start[CW-1:0])) + PW'(signed'(ref_offset[CW-1:0]));
    assign a_r0y_next = PW'(signed'(ref_start[HALF_W+CW-1:HALF_W]))
                      + PW'(signed'(ref_offset[HALF_W+CW-1:HALF_W]));
    assign a_r1x_next = PW'(signed'(ref_end[CW-1:0])) + PW'(signed'(ref_offset[CW-1:0]));
    assign a_r1y_next = PW'(signed'(ref_end[HALF_W+CW-1:HALF_W]))
                      + PW'(signed'(ref_offset[HALF_W+CW-1:HALF_W]));
    assign a_e0x_next = PW'(signed'(ext_start[CW-1:0])) + PW'(signed'(ext_offset[CW-1:0]));
    assign a_e0y_next = PW'(signed'(ext_start[HALF_W+CW-1:HALF_W]))
                      + PW'(signed'(ext_offset[HALF_W+CW-1:HALF_W]));
    assign a_e1x_next = PW'(signed'(ext_end[CW-1:0])) + PW'(signed'(ext_offset[CW-1:0]));
    assign a_e1y_next = PW'(signed'(ext_end[HALF_W+CW-1:HALF_W]))
                      + PW'(signed'(ext_offset[HALF_W+CW-1:HALF_W]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_r0x_reg <= a_r0x_next;
            a_r0y_reg <= a_r0y_next;
            a_r1x_reg <= a_r1x_next;
            a_r1y_reg <= a_r1y_next;
            a_e0x_reg <= a_e0x_next;
            a_e0y_reg <= a_e0y_next;
            a_e1x_reg <= a_e1x_next;
            a_e1y_reg <= a_e1y_next;
            a_rin_reg <= ref_inner;
            a_ein_reg <= ext_inner;
        end
    end

    // stage B: line coefficients, side-test deltas, bounding ranges
    logic signed [DW-1:0] b_a1_next, b_b1_next, b_a2_next, b_b2_next;
    logic signed [DW-1:0] b_dry_next, b_drx_next, b_dey_next, b_dex_next;
    logic signed [PW-1:0] b_xlo_next, b_xhi_next, b_ylo_next, b_yhi_next;
    logic signed [PW-1:0] rxmin, rxmax, rymin, rymax, exmin, exmax, eymin, eymax;

    logic signed [DW-1:0] b_a1_reg, b_b1_reg, b_a2_reg, b_b2_reg;
    logic signed [DW-1:0] b_dry_reg, b_drx_reg, b_dey_reg, b_dex_reg;
    logic signed [PW-1:0] b_xlo_reg, b_xhi_reg, b_ylo_reg, b_yhi_reg;
    logic signed [PW-1:0] b_r0x_reg, b_r0y_reg, b_e0x_reg, b_e0y_reg;
    logic                 b_rin_reg, b_ein_reg;

    assign b_a1_next  = DW'(a_r1y_reg) - DW'(a_r0y_reg);
    assign b_b1_next  = DW'(a_r0x_reg) - DW'(a_r1x_reg);
    assign b_a2_next  = DW'(a_e1y_reg) - DW'(a_e0y_reg);
    assign b_b2_next  = DW'(a_e0x_reg) - DW'(a_e1x_reg);
    assign b_dry_next = DW'(a_r1y_reg) - DW'(a_e0y_reg);
    assign b_drx_next = DW'(a_r1x_reg) - DW'(a_e0x_reg);
    assign b_dey_next = DW'(a_e1y_reg) - DW'(a_r0y_reg);
    assign b_dex_next = DW'(a_e1x_reg) - DW'(a_r0x_reg);

    assign rxmin = (a_r0x_reg < a_r1x_reg) ? a_r0x_reg : a_r1x_reg;
    assign rxmax = (a_r0x_reg > a_r1x_reg) ? a_r0x_reg : a_r1x_reg;
    assign rymin = (a_r0y_reg < a_r1y_reg) ? a_r0y_reg : a_r1y_reg;
    assign rymax = (a_r0y_reg > a_r1y_reg) ? a_r0y_reg : a_r1y_reg;
    assign exmin = (a_e0x_reg < a_e1x_reg) ? a_e0x_reg : a_e1x_reg;
    assign exmax = (a_e0x_reg > a_e1x_reg) ? a_e0x_reg : a_e1x_reg;
    assign eymin = (a_e0y_reg < a_e1y_reg) ? a_e0y_reg : a_e1y_reg;
    assign eymax = (a_e0y_reg > a_e1y_reg) ? a_e0y_reg : a_e1y_reg;

    assign b_xlo_next = (rxmin > exmin) ? rxmin : exmin;
    assign b_xhi_next = (rxmax < exmax) ? rxmax : exmax;
    assign b_ylo_next = (rymin > eymin) ? rymin : eymin;
    assign b_yhi_next = (rymax < eymax) ? rymax : eymax;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_a1_reg  <= b_a1_next;
            b_b1_reg  <= b_b1_next;
            b_a2_reg  <= b_a2_next;
            b_b2_reg  <= b_b2_next;
            b_dry_reg <= b_dry_next;
            b_drx_reg <= b_drx_next;
            b_dey_reg <= b_dey_next;
            b_dex_reg <= b_dex_next;
            b_xlo_reg <= b_xlo_next;
            b_xhi_reg <= b_xhi_next;
            b_ylo_reg <= b_ylo_next;
            b_yhi_reg <= b_yhi_next;
            b_r0x_reg <= a_r0x_reg;
            b_r0y_reg <= a_r0y_reg;
            b_e0x_reg <= a_e0x_reg;
            b_e0y_reg <= a_e0y_reg;
            b_rin_reg <= a_rin_reg;
            b_ein_reg <= a_ein_reg;
        end
    end

    // stage C: first products
    logic signed [MW-1:0]  c_p1_next, c_p2_next, c_p3_next, c_p4_next;
    logic signed [PPW-1:0] c_d1_next, c_d2_next;
    logic signed [PPW-1:0] c_sr1_next, c_sr2_next, c_se1_next, c_se2_next;

    logic signed [MW-1:0]  c_p1_reg, c_p2_reg, c_p3_reg, c_p4_reg;
    logic signed [PPW-1:0] c_d1_reg, c_d2_reg;
    logic signed [PPW-1:0] c_sr1_reg, c_sr2_reg, c_se1_reg, c_se2_reg;
    logic signed [DW-1:0]  c_a1_reg, c_b1_reg, c_a2_reg, c_b2_reg;
    logic signed [PW-1:0]  c_xlo_reg, c_xhi_reg, c_ylo_reg, c_yhi_reg;
    logic                  c_rin_reg, c_ein_reg;

    assign c_p1_next  = b_a1_reg * b_r0x_reg;
    assign c_p2_next  = b_b1_reg * b_r0y_reg;
    assign c_p3_next  = b_a2_reg * b_e0x_reg;
    assign c_p4_next  = b_b2_reg * b_e0y_reg;
    assign c_d1_next  = b_a1_reg * b_b2_reg;
    assign c_d2_next  = b_a2_reg * b_b1_reg;
    assign c_sr1_next = b_b2_reg * b_dry_reg;
    assign c_sr2_next = b_a2_reg * b_drx_reg;
    assign c_se1_next = b_b1_reg * b_dey_reg;
    assign c_se2_next = b_a1_reg * b_dex_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_p1_reg  <= c_p1_next;
            c_p2_reg  <= c_p2_next;
            c_p3_reg  <= c_p3_next;
            c_p4_reg  <= c_p4_next;
            c_d1_reg  <= c_d1_next;
            c_d2_reg  <= c_d2_next;
            c_sr1_reg <= c_sr1_next;
            c_sr2_reg <= c_sr2_next;
            c_se1_reg <= c_se1_next;
            c_se2_reg <= c_se2_next;
            c_a1_reg  <= b_a1_reg;
            c_b1_reg  <= b_b1_reg;
            c_a2_reg  <= b_a2_reg;
            c_b2_reg  <= b_b2_reg;
            c_xlo_reg <= b_xlo_reg;
            c_xhi_reg <= b_xhi_reg;
            c_ylo_reg <= b_ylo_reg;
            c_yhi_reg <= b_yhi_reg;
            c_rin_reg <= b_rin_reg;
            c_ein_reg <= b_ein_reg;
        end
    end

    // stage D: line constants, determinant, side flags
    logic signed [CB-1:0]   d_c1_next, d_c2_next;
    logic signed [DETW-1:0] d_det_next;
    logic signed [DETW-1:0] cpr, cpe;
    logic                   d_rinc_next, d_einc_next;

    logic signed [CB-1:0]   d_c1_reg, d_c2_reg;
    logic signed [DETW-1:0] d_det_reg;
    logic signed [DW-1:0]   d_a1_reg, d_b1_reg, d_a2_reg, d_b2_reg;
    logic signed [PW-1:0]   d_xlo_reg, d_xhi_reg, d_ylo_reg, d_yhi_reg;
    logic                   d_rinc_reg, d_einc_reg;

    assign d_c1_next  = CB'(c_p1_reg) + CB'(c_p2_reg);
    assign d_c2_next  = CB'(c_p3_reg) + CB'(c_p4_reg);
    assign d_det_next = DETW'(c_d1_reg) - DETW'(c_d2_reg);
    assign cpr        = -DETW'(c_sr1_reg) - DETW'(c_sr2_reg);
    assign cpe        = -DETW'(c_se1_reg) - DETW'(c_se2_reg);
    // reference end against external line, and the other way round
    assign d_rinc_next = cpr[DETW-1] ? !c_ein_reg : c_ein_reg;
    assign d_einc_next = cpe[DETW-1] ? !c_rin_reg : c_rin_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_c1_reg   <= d_c1_next;
            d_c2_reg   <= d_c2_next;
            d_det_reg  <= d_det_next;
            d_a1_reg   <= c_a1_reg;
            d_b1_reg   <= c_b1_reg;
            d_a2_reg   <= c_a2_reg;
            d_b2_reg   <= c_b2_reg;
            d_xlo_reg  <= c_xlo_reg;
            d_xhi_reg  <= c_xhi_reg;
            d_ylo_reg  <= c_ylo_reg;
            d_yhi_reg  <= c_yhi_reg;
            d_rinc_reg <= d_rinc_next;
            d_einc_reg <= d_einc_next;
        end
    end

    // stage E: numerator products
    logic signed [NUMW-2:0] e_m1_next, e_m2_next, e_m3_next, e_m4_next;
    logic signed [NUMW-2:0] e_m1_reg, e_m2_reg, e_m3_reg, e_m4_reg;
    logic signed [DETW-1:0] e_det_reg;
    logic signed [PW-1:0]   e_xlo_reg, e_xhi_reg, e_ylo_reg, e_yhi_reg;
    logic                   e_rinc_reg, e_einc_reg;

    assign e_m1_next = d_b2_reg * d_c1_reg;
    assign e_m2_next = d_b1_reg * d_c2_reg;
    assign e_m3_next = d_a1_reg * d_c2_reg;
    assign e_m4_next = d_a2_reg * d_c1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_m1_reg   <= e_m1_next;
            e_m2_reg   <= e_m2_next;
            e_m3_reg   <= e_m3_next;
            e_m4_reg   <= e_m4_next;
            e_det_reg  <= d_det_reg;
            e_xlo_reg  <= d_xlo_reg;
            e_xhi_reg  <= d_xhi_reg;
            e_ylo_reg  <= d_ylo_reg;
            e_yhi_reg  <= d_yhi_reg;
            e_rinc_reg <= d_rinc_reg;
            e_einc_reg <= d_einc_reg;
        end
    end

    // stage F: numerators
    logic signed [NUMW-1:0] f_nx_next, f_ny_next;
    logic signed [NUMW-1:0] f_nx_reg, f_ny_reg;
    logic signed [DETW-1:0] f_det_reg;
    logic signed [PW-1:0]   f_xlo_reg, f_xhi_reg, f_ylo_reg, f_yhi_reg;
    logic                   f_rinc_reg, f_einc_reg;

    assign f_nx_next = NUMW'(e_m1_reg) - NUMW'(e_m2_reg);
    assign f_ny_next = NUMW'(e_m3_reg) - NUMW'(e_m4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_nx_reg   <= f_nx_next;
            f_ny_reg   <= f_ny_next;
            f_det_reg  <= e_det_reg;
            f_xlo_reg  <= e_xlo_reg;
            f_xhi_reg  <= e_xhi_reg;
            f_ylo_reg  <= e_ylo_reg;
            f_yhi_reg  <= e_yhi_reg;
            f_rinc_reg <= e_rinc_reg;
            f_einc_reg <= e_einc_reg;
        end
    end

    // stage G: magnitudes; divide 2|n| by |det| so the low quotient bit rounds
    logic [NUMW-1:0] absx, absy;
    logic [DETW-1:0] g_den_next;
    logic [NXW-1:0]  g_nx_next, g_ny_next;
    side_t           g_side_next;

    logic [NXW-1:0]  g_nx_reg, g_ny_reg;
    logic [DETW-1:0] g_den_reg;
    side_t           g_side_reg;

    assign absx       = f_nx_reg[NUMW-1] ? NUMW'(-f_nx_reg) : NUMW'(f_nx_reg);
    assign absy       = f_ny_reg[NUMW-1] ? NUMW'(-f_ny_reg) : NUMW'(f_ny_reg);
    assign g_den_next = f_det_reg[DETW-1] ? DETW'(-f_det_reg) : DETW'(f_det_reg);
    assign g_nx_next  = NXW'({absx, 1'b0});
    assign g_ny_next  = NXW'({absy, 1'b0});

    always_comb
    begin
        g_side_next.xlo  = f_xlo_reg;
        g_side_next.xhi  = f_xhi_reg;
        g_side_next.ylo  = f_ylo_reg;
        g_side_next.yhi  = f_yhi_reg;
        g_side_next.detz = (f_det_reg == '0);
        g_side_next.negx = f_nx_reg[NUMW-1] ^ f_det_reg[DETW-1];
        g_side_next.negy = f_ny_reg[NUMW-1] ^ f_det_reg[DETW-1];
        g_side_next.rinc = f_rinc_reg;
        g_side_next.einc = f_einc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_nx_reg   <= g_nx_next;
            g_ny_reg   <= g_ny_next;
            g_den_reg  <= g_den_next;
            g_side_reg <= g_side_next;
        end
    end

    // divider stages: QB + 1 registers
    logic [QB-1:0] qx, qy;
    logic          ovfx, ovfy;
    side_t         dly_reg [QB+1];

    sis_div #(.NW(NXW), .DW(DETW), .QB(QB)) u_div_x
    (
        .clk (clk),
        .en  (en),
        .num (g_nx_reg),
        .den (g_den_reg),
        .quo (qx),
        .ovf (ovfx)
    );

    sis_div #(.NW(NXW), .DW(DETW), .QB(QB)) u_div_y
    (
        .clk (clk),
        .en  (en),
        .num (g_ny_reg),
        .den (g_den_reg),
        .quo (qy),
        .ovf (ovfy)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= g_side_reg;
            for (int i = 1; i <= QB; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    // stage R1: round half away from zero, saturate, apply sign
    logic [QB:0]             rqx, rqy;
    logic [QB-1:0]           magx, magy;
    logic signed [RES_W-1:0] r_x_next, r_y_next;
    logic signed [RES_W-1:0] r_x_reg, r_y_reg;
    side_t                   r_side_reg;

    assign rqx  = {1'b0, qx} + (QB+1)'(1);
    assign rqy  = {1'b0, qy} + (QB+1)'(1);
    assign magx = rqx[QB:1];
    assign magy = rqy[QB:1];

    always_comb
    begin
        if (dly_reg[QB].negx)
        begin
            r_x_next = (ovfx || magx > QB'(NEG_MIN)) ? NEG_MIN : -magx[RES_W-1:0];
        end
        else
        begin
            r_x_next = (ovfx || magx > QB'(POS_MAX)) ? POS_MAX : magx[RES_W-1:0];
        end
        if (dly_reg[QB].negy)
        begin
            r_y_next = (ovfy || magy > QB'(NEG_MIN)) ? NEG_MIN : -magy[RES_W-1:0];
        end
        else
        begin
            r_y_next = (ovfy || magy > QB'(POS_MAX)) ? POS_MAX : magy[RES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_x_reg    <= r_x_next;
            r_y_reg    <= r_y_next;
            r_side_reg <= dly_reg[QB];
        end
    end

    // stage R2: range test, zero everything for parallel lines
    logic                    o_hit_next;
    logic                    o_hit_reg, o_rinc_reg, o_einc_reg;
    logic signed [RES_W-1:0] o_x_reg, o_y_reg;

    assign o_hit_next = !r_side_reg.detz
                     && r_x_reg <= RES_W'(r_side_reg.xhi) && r_x_reg >= RES_W'(r_side_reg.xlo)
                     && r_y_reg <= RES_W'(r_side_reg.yhi) && r_y_reg >= RES_W'(r_side_reg.ylo);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_hit_reg  <= o_hit_next;
            o_x_reg    <= r_side_reg.detz ? '0 : r_x_reg;
            o_y_reg    <= r_side_reg.detz ? '0 : r_y_reg;
            o_rinc_reg <= r_side_reg.rinc && !r_side_reg.detz;
            o_einc_reg <= r_side_reg.einc && !r_side_reg.detz;
        end
    end

    assign out_valid    = vld_reg[NST-1];
    assign intersected  = o_hit_reg;
    assign cross_x      = o_x_reg;
    assign cross_y      = o_y_reg;
    assign ref_incoming = o_rinc_reg;
    assign ext_incoming = o_einc_reg;

endmodule

/* rtl/sis_chk.sv */
// Port-level checker for segment_intersection_with_sides, bound to the top level.
// Depends on sis_pkg for the result width.
module sis_chk
    import sis_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    intersected,
    input logic signed [RES_W-1:0] cross_x,
    input logic signed [RES_W-1:0] cross_y,
    input logic                    ref_incoming,
    input logic                    ext_incoming
);

    // a stalled output word keeps its valid, crossing point and hit flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cross_x) && $stable(cross_y)
            && $stable(intersected))
        else $error("output word changed while stalled");

    // the pipeline takes a word exactly when its output side can move
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (out_ready || !out_valid))
        else $error("input ready does not follow output stall");

    // a hit point lies within translated coordinate range
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && intersected |->
            cross_x >= -32'sd65536 && cross_x <= 32'sd65534
            && cross_y >= -32'sd65536 && cross_y <= 32'sd65534)
        else $error("hit reported outside coordinate range");

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind segment_intersection_with_sides sis_chk u_sis_chk (.*);
